// ----- rtl/keyed_frame_metadata_queue_unit_macros.svh -----
// Assertion macros for the keyed frame metadata queue.
// Used by the top level; expects clk and rst in scope.
`ifndef KEYED_FRAME_METADATA_QUEUE_UNIT_MACROS_SVH
`define KEYED_FRAME_METADATA_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, off during reset
`define KFQ_AST_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kfq assertion failed");

// Next-cycle implication, off during reset
`define KFQ_AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kfq assertion failed");

`endif

// ----- rtl/kfq_pkg.sv -----
// Package for the keyed frame metadata queue: sizes, operation codes, entry type.
// No dependencies.
`default_nettype none
package kfq_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [3:0] FN_PUSH     = 4'd0;
  localparam logic [3:0] FN_POP      = 4'd1;
  localparam logic [3:0] FN_POPKEY   = 4'd2;
  localparam logic [3:0] FN_PEEKKEY  = 4'd3;
  localparam logic [3:0] FN_PEEKF    = 4'd4;
  localparam logic [3:0] FN_PEEKB    = 4'd5;
  localparam logic [3:0] FN_SETNEXT  = 4'd6;
  localparam logic [3:0] FN_SETACQ   = 4'd7;
  localparam logic [3:0] FN_INVAL    = 4'd8;
  localparam logic [3:0] FN_MISSED   = 4'd9;
  localparam logic [3:0] FN_VRANGE   = 4'd10;
  localparam logic [3:0] FN_EMPTY    = 4'd11;
  localparam logic [3:0] FN_SIZE     = 4'd12;
  localparam logic [3:0] FN_ALLTYPE  = 4'd13;

  // One stored queue entry
  typedef struct packed {
    logic [3:0]  ptype;
    logic [3:0]  rtype;
    logic        batch;
    logic        trig;
    logic [31:0] exposure;
    logic [31:0] delay;
    logic [63:0] after_t;
    logic [63:0] before_t;
    logic [31:0] vblank;
    logic [63:0] next_t;
    logic [63:0] pres;
    logic [31:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Latched request
  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] key;
    logic [63:0] time_a;
    logic [63:0] time_b;
    logic [31:0] vblank_low;
    logic [31:0] vblank_high;
    logic [31:0] delay_ms;
    logic [31:0] exposure_ms;
    logic        flag_a;
    logic        flag_b;
    logic [3:0]  image_kind;
    logic [3:0]  pattern_kind;
  } req_t;

endpackage
`default_nettype wire

// ----- rtl/kfq_if.sv -----
// Valid/ready channel interfaces for the queue's requests and responses.
// No dependencies.
`default_nettype none
interface kfq_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [31:0] key;
  logic [63:0] time_a;
  logic [63:0] time_b;
  logic [31:0] vblank_low;
  logic [31:0] vblank_high;
  logic [31:0] delay_ms;
  logic [31:0] exposure_ms;
  logic        flag_a;
  logic        flag_b;
  logic [3:0]  image_kind;
  logic [3:0]  pattern_kind;
  modport source (output valid, func, key, time_a, time_b, vblank_low, vblank_high,
                  delay_ms, exposure_ms, flag_a, flag_b, image_kind, pattern_kind,
                  input ready);
  modport sink (input valid, func, key, time_a, time_b, vblank_low, vblank_high,
                delay_ms, exposure_ms, flag_a, flag_b, image_kind, pattern_kind,
                output ready);
endinterface

interface kfq_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [6:0]  count;
  logic [31:0] out_key;
  logic [63:0] out_presented_time;
  logic [63:0] out_next_presented_time;
  logic [31:0] out_vblank;
  logic        out_triggered;
  logic        out_batch;
  logic [63:0] out_before_trigger;
  logic [63:0] out_after_trigger;
  logic [31:0] out_delay;
  logic [31:0] out_exposure;
  modport source (output valid, ok, count, out_key, out_presented_time,
                  out_next_presented_time, out_vblank, out_triggered, out_batch,
                  out_before_trigger, out_after_trigger, out_delay, out_exposure,
                  input ready);
  modport sink (input valid, ok, count, out_key, out_presented_time,
                out_next_presented_time, out_vblank, out_triggered, out_batch,
                out_before_trigger, out_after_trigger, out_delay, out_exposure,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/keyed_frame_metadata_queue_unit.sv -----
// Keyed frame metadata queue, top level: sequencer over one entry RAM.
// Depends on kfq_pkg, kfq_if, kfq_ram and the assertion macro header.
`default_nettype none
`include "keyed_frame_metadata_queue_unit_macros.svh"

// An ordered queue of up to 64 frame metadata entries held in one RAM with a
// single read and a single write port. One request is taken at a time; ready is
// high only while the sequencer is idle. Push, empty and size need no walk.
// Searches, peeks, updates, filters and the type test walk the queue one entry
// at a time: an address step, then an evaluation of the registered read data.
// A pop also shifts the entries behind the removed one down, reading each and
// writing it one place lower. A pop by key then re-sorts by presentation time
// with bubble passes, repeated until a pass makes no swap (at most n passes for
// n entries). The finished result sits in an output register until it is
// transferred.
module keyed_frame_metadata_queue_unit (
  input wire logic clk,
  input wire logic rst,
  kfq_req_if.sink   req,
  kfq_rsp_if.source rsp
);
  import kfq_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PUSH     = 4'd1;
  localparam logic [3:0] ST_RD       = 4'd2;
  localparam logic [3:0] ST_EV       = 4'd3;
  localparam logic [3:0] ST_SH_RD    = 4'd4;
  localparam logic [3:0] ST_SH_WR    = 4'd5;
  localparam logic [3:0] ST_SO_START = 4'd6;
  localparam logic [3:0] ST_SO_LD    = 4'd7;
  localparam logic [3:0] ST_SO_RD    = 4'd8;
  localparam logic [3:0] ST_SO_EV    = 4'd9;
  localparam logic [3:0] ST_OUT      = 4'd10;

  logic [3:0]    state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] w, w_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          ok, ok_next;
  logic          swapped, swapped_next;
  req_t          op, op_next;
  entry_t        res, res_next;
  entry_t        cur, cur_next;

  logic          out_valid;
  logic          out_ok;
  logic [CW-1:0] out_cnt;
  entry_t        out_e;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  logic acc;
  logic out_free;

  assign req.ready = (state == ST_IDLE);
  assign acc       = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  kfq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer
  always_comb begin
    entry_t        e;
    logic          is_back;
    logic          last;
    logic          hit;
    logic          keep;
    logic [CW-1:0] step;
    logic [CW-1:0] nidx;
    logic [CW-1:0] w_inc;
    logic [CW-1:0] fill_dec;

    e        = entry_t'(mem_rdata);
    is_back  = (op.func == FN_PEEKB) || (op.func == FN_SETNEXT) || (op.func == FN_SETACQ);
    last     = is_back ? (idx == '0) : (idx == fill - CW'(1));
    step     = is_back ? idx - CW'(1) : idx + CW'(1);
    nidx     = idx + CW'(1);
    fill_dec = fill - CW'(1);
    keep     = 1'b0;
    hit      = 1'b0;
    w_inc    = w;

    state_next   = state;
    fill_next    = fill;
    idx_next     = idx;
    w_next       = w;
    j_next       = j;
    cnt_next     = cnt;
    ok_next      = ok;
    swapped_next = swapped;
    op_next      = op;
    res_next     = res;
    cur_next     = cur;
    mem_we       = 1'b0;
    mem_waddr    = idx[AW-1:0];
    mem_wdata    = e;
    mem_raddr    = idx[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          op_next  = '{req.func, req.key, req.time_a, req.time_b, req.vblank_low,
                       req.vblank_high, req.delay_ms, req.exposure_ms, req.flag_a,
                       req.flag_b, req.image_kind, req.pattern_kind};
          res_next = '0;
          ok_next  = 1'b0;
          cnt_next = '0;
          w_next   = '0;
          idx_next = '0;
          unique case (req.func) inside
            FN_PUSH: state_next = ST_PUSH;
            FN_EMPTY: begin
              fill_next  = '0;
              ok_next    = 1'b1;
              state_next = ST_OUT;
            end
            FN_SIZE: begin
              cnt_next   = fill;
              ok_next    = 1'b1;
              state_next = ST_OUT;
            end
            FN_ALLTYPE, FN_MISSED, FN_VRANGE: begin
              ok_next    = 1'b1;
              state_next = (fill == '0) ? ST_OUT : ST_RD;
            end
            FN_POP, FN_POPKEY, FN_PEEKKEY, FN_PEEKF, FN_PEEKB, FN_SETNEXT,
            FN_SETACQ, FN_INVAL: begin
              if (req.func == FN_PEEKB || req.func == FN_SETNEXT ||
                  req.func == FN_SETACQ) begin
                idx_next = fill - CW'(1);
              end
              state_next = (fill == '0) ? ST_OUT : ST_RD;
            end
            default: state_next = ST_OUT;
          endcase
        end
      end

      // Append at the back when there is room
      ST_PUSH: begin
        if (fill < CW'(DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = fill[AW-1:0];
          mem_wdata = '{op.pattern_kind, op.image_kind, op.flag_b, op.flag_a,
                        op.exposure_ms, op.delay_ms, '1, '1, op.vblank_low, '1,
                        op.time_a, op.key};
          fill_next = fill + CW'(1);
          ok_next   = 1'b1;
        end
        state_next = ST_OUT;
      end

      ST_RD: begin
        mem_raddr  = idx[AW-1:0];
        state_next = ST_EV;
      end

      // Evaluate one entry of the walk
      ST_EV: begin
        case (op.func) inside
          FN_MISSED, FN_VRANGE: begin
            if (op.func == FN_MISSED) begin
              keep = e.trig || !($signed(e.pres) < $signed(op.time_a));
            end else begin
              keep = ($signed(op.vblank_low) <= $signed(e.vblank)) &&
                     ($signed(e.vblank) <= $signed(op.vblank_high));
            end
            if (keep) begin
              mem_we    = 1'b1;
              mem_waddr = w[AW-1:0];
              mem_wdata = e;
              w_inc     = w + CW'(1);
            end else if (op.func == FN_MISSED) begin
              cnt_next = cnt + CW'(1);
            end
            w_next = w_inc;
            if (last) begin
              fill_next  = w_inc;
              state_next = ST_OUT;
            end else begin
              idx_next   = step;
              state_next = ST_RD;
            end
          end
          FN_ALLTYPE: begin
            if (e.rtype != op.image_kind || e.ptype != op.pattern_kind) begin
              ok_next = 1'b0;
            end
            if (last) begin
              state_next = ST_OUT;
            end else begin
              idx_next   = step;
              state_next = ST_RD;
            end
          end
          default: begin
            case (op.func) inside
              FN_POPKEY, FN_PEEKKEY, FN_SETNEXT, FN_SETACQ: hit = (e.key == op.key);
              FN_INVAL: hit = !e.trig;
              default:  hit = !op.flag_a || e.trig;
            endcase
            if (hit) begin
              ok_next = 1'b1;
              case (op.func) inside
                FN_SETNEXT: begin
                  mem_we           = 1'b1;
                  mem_wdata.next_t = op.time_a;
                  state_next       = ST_OUT;
                end
                FN_SETACQ: begin
                  mem_we             = 1'b1;
                  mem_wdata.delay    = op.delay_ms;
                  mem_wdata.exposure = op.exposure_ms;
                  mem_wdata.before_t = op.time_a;
                  mem_wdata.after_t  = op.time_b;
                  mem_wdata.trig     = op.flag_a;
                  mem_wdata.batch    = op.flag_b && e.batch;
                  state_next         = ST_OUT;
                end
                FN_INVAL: begin
                  mem_we          = 1'b1;
                  mem_wdata.trig  = 1'b1;
                  mem_wdata.batch = 1'b0;
                  state_next      = ST_OUT;
                end
                FN_POP, FN_POPKEY: begin
                  res_next   = e;
                  state_next = ST_SH_RD;
                end
                default: begin
                  res_next   = e;
                  state_next = ST_OUT;
                end
              endcase
            end else if (last) begin
              state_next = ST_OUT;
            end else begin
              idx_next   = step;
              state_next = ST_RD;
            end
          end
        endcase
      end

      // Shift the tail down over the removed entry
      ST_SH_RD: begin
        if (nidx < fill) begin
          mem_raddr  = nidx[AW-1:0];
          state_next = ST_SH_WR;
        end else begin
          fill_next = fill_dec;
          if (op.func == FN_POPKEY && fill_dec > CW'(1)) begin
            state_next = ST_SO_START;
          end else begin
            state_next = ST_OUT;
          end
        end
      end

      ST_SH_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = e;
        idx_next   = nidx;
        state_next = ST_SH_RD;
      end

      // Bubble pass: carry the larger entry toward the back
      ST_SO_START: begin
        mem_raddr    = '0;
        j_next       = CW'(1);
        swapped_next = 1'b0;
        state_next   = ST_SO_LD;
      end

      ST_SO_LD: begin
        cur_next   = e;
        state_next = ST_SO_RD;
      end

      ST_SO_RD: begin
        if (j < fill) begin
          mem_raddr  = j[AW-1:0];
          state_next = ST_SO_EV;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = fill_dec[AW-1:0];
          mem_wdata  = cur;
          state_next = swapped ? ST_SO_START : ST_OUT;
        end
      end

      ST_SO_EV: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j - CW'(1));
        if ($signed(e.pres) < $signed(cur.pres)) begin
          mem_wdata    = e;
          swapped_next = 1'b1;
        end else begin
          mem_wdata = cur;
          cur_next  = e;
        end
        j_next     = j + CW'(1);
        state_next = ST_SO_RD;
      end

      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    w       <= w_next;
    j       <= j_next;
    cnt     <= cnt_next;
    ok      <= ok_next;
    swapped <= swapped_next;
    op      <= op_next;
    res     <= res_next;
    cur     <= cur_next;
    if (state == ST_OUT && out_free) begin
      out_ok  <= ok;
      out_cnt <= cnt;
      out_e   <= res;
    end
  end

  assign rsp.valid                   = out_valid;
  assign rsp.ok                      = out_ok;
  assign rsp.count                   = 7'(out_cnt);
  assign rsp.out_key                 = out_e.key;
  assign rsp.out_presented_time      = out_e.pres;
  assign rsp.out_next_presented_time = out_e.next_t;
  assign rsp.out_vblank              = out_e.vblank;
  assign rsp.out_triggered           = out_e.trig;
  assign rsp.out_batch               = out_e.batch;
  assign rsp.out_before_trigger      = out_e.before_t;
  assign rsp.out_after_trigger       = out_e.after_t;
  assign rsp.out_delay               = out_e.delay;
  assign rsp.out_exposure            = out_e.exposure;

  `KFQ_AST_NOW(a_fill_range, 1'b1, fill <= CW'(DEPTH))
  `KFQ_AST_NXT(a_accept_busy, acc, state != ST_IDLE)
  `KFQ_AST_NOW(a_idle_no_write, state == ST_IDLE, !mem_we)
  `KFQ_AST_NXT(a_result_shown, state == ST_OUT && out_free, rsp.valid)

endmodule
`default_nettype wire

// ----- rtl/kfq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
